FILE: hdl/rcfa_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rcfa_pkg
// Shared types and constants of the reference-counted frame allocator:
// operation and status codes, beat payloads and the count evaluation record.
// ----------------------------------------------------------------------------
package rcfa_pkg;

   localparam int MAX_FRAMES_DEF = 4096;
   localparam int ADDR_W         = 32;
   localparam int PAGE_SHIFT     = 12;
   localparam int PG_W           = ADDR_W - PAGE_SHIFT;
   localparam int FREE_W         = 13;
   localparam int COUNT_W        = 8;
   localparam logic [COUNT_W-1:0] COUNT_MAX = 8'd255;

   typedef enum logic [1:0] {
      FUNC_ALLOC = 2'd0,
      FUNC_REF   = 2'd1,
      FUNC_UNREF = 2'd2,
      FUNC_NOP   = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_EXHAUSTED = 2'd1,
      ST_OUTSIDE   = 2'd2,
      ST_FREE      = 2'd3
   } status_type;

   localparam logic CSR_REGION_START = 1'b0;
   localparam logic CSR_REGION_END   = 1'b1;

   typedef struct packed {
      func_type            func;
      logic [ADDR_W-1:0]   frame_addr;
   } req_type;

   typedef struct packed {
      logic [ADDR_W-1:0]   alloc_addr;
      status_type          status;
      logic [FREE_W-1:0]   free_frames;
   } rsp_type;

   // verdict of the count unit on one stored count
   typedef struct packed {
      logic                is_free;
      logic                wr_en;
      logic                freed;
      logic [COUNT_W-1:0]  new_cnt;
      status_type          status;
   } eval_type;

endpackage
`default_nettype wire

FILE: hdl/refcounted_frame_allocator.sv
`default_nettype none
// ----------------------------------------------------------------------------
// refcounted_frame_allocator
// Page-frame pool with an 8-bit reference count per frame and next-fit
// allocation from a wrapping hint.
// ----------------------------------------------------------------------------
// One operation is handled at a time by a small sequencer around the count
// memory and a shared count unit. Add and drop reference pass through
// S_LOCATE (count read), S_MODIFY (count judged and written back) and
// S_DONE (result handed to the output register). Allocate probes frames
// from the hint in S_SCAN, one frame per cycle through the memory read
// port, until a free frame is found or every pool frame has been probed.
// A new request is taken the cycle after the result is handed to the
// output register, which lets the result wait while the next request runs.
// After reset and after every region register write all MAX_FRAMES count
// entries are cleared by a pass, during which req_ready stays low.
// ----------------------------------------------------------------------------
module refcounted_frame_allocator
   import rcfa_pkg::*;
#(
   parameter int MAX_FRAMES = MAX_FRAMES_DEF
) (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 req_valid,
   output logic                req_ready,
   input  req_type             req_data,
   output logic                rsp_valid,
   input  wire                 rsp_ready,
   output rsp_type             rsp_data,
   input  wire                 csr_we,
   input  wire                 csr_index,
   input  wire  [ADDR_W-1:0]   csr_wdata
);

   localparam int IDX_W = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
   localparam int CNT_W = $clog2(MAX_FRAMES + 1);
   localparam int PGX_W = PG_W + 1;

   typedef enum logic [2:0] {
      S_INIT,
      S_CLEAR,
      S_IDLE,
      S_LOCATE,
      S_MODIFY,
      S_SCAN,
      S_DONE
   } state_type;

   state_type           state_ff, state_in;
   logic [ADDR_W-1:0]   start_ff, start_in;
   logic [ADDR_W-1:0]   end_ff, end_in;
   logic [PG_W-1:0]     base_pg_ff, base_pg_in;
   logic [CNT_W-1:0]    total_ff, total_in;
   logic [CNT_W-1:0]    free_ff, free_in;
   logic [IDX_W-1:0]    hint_ff, hint_in;
   logic [IDX_W-1:0]    clr_ff, clr_in;
   req_type             req_ff, req_in;
   logic [IDX_W-1:0]    idx_ff, idx_in;
   logic                in_range_ff, in_range_in;
   logic [IDX_W-1:0]    probe_ff, probe_in;
   logic [CNT_W-1:0]    left_ff, left_in;
   logic [IDX_W-1:0]    look_idx_ff, look_idx_in;
   logic                look_vld_ff, look_vld_in;
   logic [ADDR_W-1:0]   res_addr_ff, res_addr_in;
   status_type          res_status_ff, res_status_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_data_ff, rsp_data_in;

   // pool geometry in page units
   logic [PGX_W-1:0]    lo_pg, end_pg, hi_pg, span;
   logic                pool_ok;
   // frame lookup for add and drop reference
   logic [PG_W-1:0]     addr_pg, off_pg;
   logic                loc_in;
   logic [IDX_W-1:0]    loc_idx;
   // wrap of the scan pointer and of the hint
   logic [CNT_W-1:0]    probe_nxt, look_nxt;
   logic [IDX_W-1:0]    probe_wrap, look_wrap;

   logic                ram_we;
   logic [IDX_W-1:0]    ram_waddr, ram_raddr;
   logic [COUNT_W-1:0]  ram_wdata, ram_rdata;
   eval_type            eval;

   rcfa_count_ram #(
      .DEPTH (MAX_FRAMES)
   ) u_count_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   rcfa_step_unit u_step_unit (
      .func     (req_ff.func),
      .in_range (in_range_ff),
      .count    (ram_rdata),
      .eval     (eval)
   );

   always_comb begin
      lo_pg   = PGX_W'(start_ff[ADDR_W-1:PAGE_SHIFT])
              + PGX_W'(start_ff[PAGE_SHIFT-1:0] != '0);
      end_pg  = PGX_W'(end_ff[ADDR_W-1:PAGE_SHIFT]);
      hi_pg   = (end_pg > PGX_W'(MAX_FRAMES)) ? PGX_W'(MAX_FRAMES) : end_pg;
      pool_ok = (hi_pg > lo_pg);
      span    = hi_pg - lo_pg;
   end

   always_comb begin
      addr_pg = req_ff.frame_addr[ADDR_W-1:PAGE_SHIFT];
      off_pg  = addr_pg - base_pg_ff;
      loc_in  = (addr_pg >= base_pg_ff) && (PGX_W'(off_pg) < PGX_W'(total_ff));
      loc_idx = off_pg[IDX_W-1:0];
   end

   always_comb begin
      probe_nxt  = CNT_W'(probe_ff) + CNT_W'(1);
      probe_wrap = (probe_nxt == total_ff) ? '0 : probe_nxt[IDX_W-1:0];
      look_nxt   = CNT_W'(look_idx_ff) + CNT_W'(1);
      look_wrap  = (look_nxt == total_ff) ? '0 : look_nxt[IDX_W-1:0];
   end

   always_comb begin
      state_in      = state_ff;
      start_in      = start_ff;
      end_in        = end_ff;
      base_pg_in    = base_pg_ff;
      total_in      = total_ff;
      free_in       = free_ff;
      hint_in       = hint_ff;
      clr_in        = clr_ff;
      req_in        = req_ff;
      idx_in        = idx_ff;
      in_range_in   = in_range_ff;
      probe_in      = probe_ff;
      left_in       = left_ff;
      look_idx_in   = look_idx_ff;
      look_vld_in   = look_vld_ff;
      res_addr_in   = res_addr_ff;
      res_status_in = res_status_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      ram_we        = 1'b0;
      ram_waddr     = clr_ff;
      ram_wdata     = '0;
      ram_raddr     = probe_ff;
      req_ready     = (state_ff == S_IDLE);

      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_INIT: begin
            base_pg_in = pool_ok ? lo_pg[PG_W-1:0] : '0;
            total_in   = pool_ok ? CNT_W'(span) : '0;
            free_in    = pool_ok ? CNT_W'(span) : '0;
            hint_in    = '0;
            clr_in     = '0;
            state_in   = S_CLEAR;
         end
         S_CLEAR: begin
            ram_we    = 1'b1;
            ram_waddr = clr_ff;
            clr_in    = clr_ff + IDX_W'(1);
            if (clr_ff == IDX_W'(MAX_FRAMES - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               req_in        = req_data;
               res_addr_in   = '0;
               res_status_in = ST_OK;
               unique case (req_data.func) inside
                  FUNC_ALLOC: begin
                     probe_in    = hint_ff;
                     left_in     = total_ff;
                     look_vld_in = 1'b0;
                     state_in    = S_SCAN;
                  end
                  FUNC_REF, FUNC_UNREF: begin
                     state_in = S_LOCATE;
                  end
                  default: begin
                     state_in = S_DONE;
                  end
               endcase
            end
         end
         S_LOCATE: begin
            ram_raddr   = loc_idx;
            idx_in      = loc_idx;
            in_range_in = loc_in;
            state_in    = S_MODIFY;
         end
         S_MODIFY: begin
            if (eval.wr_en) begin
               ram_we    = 1'b1;
               ram_waddr = idx_ff;
               ram_wdata = eval.new_cnt;
            end
            if (eval.freed) begin
               free_in = free_ff + CNT_W'(1);
            end
            res_status_in = eval.status;
            state_in      = S_DONE;
         end
         S_SCAN: begin
            // one probe issued while budget remains and one read beat checked each cycle
            if (look_vld_ff && eval.is_free) begin
               ram_we        = 1'b1;
               ram_waddr     = look_idx_ff;
               ram_wdata     = eval.new_cnt;
               free_in       = free_ff - CNT_W'(1);
               hint_in       = look_wrap;
               res_addr_in   = {PG_W'(base_pg_ff + PG_W'(look_idx_ff)),
                                {PAGE_SHIFT{1'b0}}};
               res_status_in = ST_OK;
               state_in      = S_DONE;
            end else if (left_ff != '0) begin
               ram_raddr   = probe_ff;
               look_idx_in = probe_ff;
               look_vld_in = 1'b1;
               probe_in    = probe_wrap;
               left_in     = left_ff - CNT_W'(1);
            end else if (!look_vld_ff) begin
               res_status_in = ST_EXHAUSTED;
               state_in      = S_DONE;
            end else begin
               look_vld_in = 1'b0;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in            = 1'b1;
               rsp_data_in.alloc_addr  = res_addr_ff;
               rsp_data_in.status      = res_status_ff;
               rsp_data_in.free_frames = FREE_W'(free_ff);
               state_in                = S_IDLE;
            end
         end
         default: begin
            state_in = S_INIT;
         end
      endcase

      // a region write rebuilds the pool
      if (csr_we) begin
         if (csr_index == CSR_REGION_START) begin
            start_in = csr_wdata;
         end else begin
            end_in = csr_wdata;
         end
         state_in = S_INIT;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         start_ff     <= '0;
         end_ff       <= '0;
         base_pg_ff   <= '0;
         total_ff     <= '0;
         free_ff      <= '0;
         hint_ff      <= '0;
         clr_ff       <= '0;
         left_ff      <= '0;
         look_vld_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         start_ff     <= start_in;
         end_ff       <= end_in;
         base_pg_ff   <= base_pg_in;
         total_ff     <= total_in;
         free_ff      <= free_in;
         hint_ff      <= hint_in;
         clr_ff       <= clr_in;
         left_ff      <= left_in;
         look_vld_ff  <= look_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      req_ff        <= req_in;
      idx_ff        <= idx_in;
      in_range_ff   <= in_range_in;
      probe_ff      <= probe_in;
      look_idx_ff   <= look_idx_in;
      res_addr_ff   <= res_addr_in;
      res_status_ff <= res_status_in;
      rsp_data_ff   <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTHESIS
   a_free_bounded: assert property (@(posedge clock) disable iff (reset)
      free_ff <= total_ff)
      else $error("free frame count above pool size");

   a_fail_no_addr: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status != ST_OK) |-> rsp_data.alloc_addr == '0)
      else $error("failed result beat carries an address");

   a_hint_in_pool: assert property (@(posedge clock) disable iff (reset)
      (hint_ff == '0) || (CNT_W'(hint_ff) < total_ff))
      else $error("allocation hint outside pool");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while another is in progress");

   a_scan_budget: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_SCAN |-> left_ff <= total_ff)
      else $error("scan budget above pool size");
`endif

endmodule
`default_nettype wire

FILE: hdl/rcfa_count_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rcfa_count_ram
// Reference count store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module rcfa_count_ram
   import rcfa_pkg::*;
#(
   parameter int DEPTH = MAX_FRAMES_DEF
) (
   input  wire                                            clock,
   input  wire                                            we,
   input  wire  [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]   waddr,
   input  wire  [COUNT_W-1:0]                             wdata,
   input  wire  [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]   raddr,
   output logic [COUNT_W-1:0]                             rdata
);

   logic [COUNT_W-1:0] mem [DEPTH];
   logic [COUNT_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule
`default_nettype wire

FILE: hdl/rcfa_step_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rcfa_step_unit
// Shared count unit: judges one stored count for allocate, add reference or
// drop reference and gives the new count, write strobe and status.
// ----------------------------------------------------------------------------
module rcfa_step_unit
   import rcfa_pkg::*;
(
   input  func_type              func,
   input  wire                   in_range,
   input  wire  [COUNT_W-1:0]    count,
   output eval_type              eval
);

   always_comb begin
      eval         = '0;
      eval.is_free = (count == '0);
      eval.status  = ST_OK;
      unique case (func)
         FUNC_ALLOC: begin
            eval.wr_en   = eval.is_free;
            eval.new_cnt = COUNT_W'(1);
         end
         FUNC_REF: begin
            if (!in_range) begin
               eval.status = ST_OUTSIDE;
            end else if (eval.is_free) begin
               eval.status = ST_FREE;
            end else begin
               // saturates at the top count
               eval.wr_en   = (count != COUNT_MAX);
               eval.new_cnt = count + COUNT_W'(1);
            end
         end
         FUNC_UNREF: begin
            if (!in_range) begin
               eval.status = ST_OUTSIDE;
            end else if (eval.is_free) begin
               eval.status = ST_FREE;
            end else begin
               eval.wr_en   = 1'b1;
               eval.new_cnt = count - COUNT_W'(1);
               eval.freed   = (count == COUNT_W'(1));
            end
         end
         default: begin
            eval.wr_en = 1'b0;
         end
      endcase
   end

endmodule
`default_nettype wire
